FILE: rtl/core/dcfr_pkg.sv
// shared types, codes and defaults for the dmx change filter router
// no dependencies; used by every file under rtl/core
package dcfr_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int UNIVERSES_DEF = 16;
	localparam int CHANNELS_DEF  = 512;

	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam int KIND_W = 2;
	localparam int UNI_W  = 4;
	localparam int CH_W   = 10;
	localparam int VAL_W  = 8;
	localparam int SUB_W  = 4;

	localparam logic [KIND_W-1:0] KIND_EVENT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SLOTWR = 2'd2;

	localparam logic DIR_IN  = 1'b0;
	localparam logic DIR_OUT = 1'b1;

	typedef struct packed {
		logic             dir;
		logic [UNI_W-1:0] min_uni;
		logic [UNI_W-1:0] max_uni;
		logic [CH_W-1:0]  min_ch;
		logic [CH_W-1:0]  max_ch;
	} slot_cfg_t;

	typedef struct packed {
		logic             dir;
		logic [UNI_W-1:0] uni;
		logic [CH_W-1:0]  ch;
	} probe_t;

	typedef struct packed {
		logic [UNI_W-1:0] uni;
		logic [CH_W-1:0]  ch;
		logic [VAL_W-1:0] val;
	} frame_req_t;

endpackage

FILE: rtl/core/dcfr_slot_table.sv
// subscriber slot table with one registered read port and the shared match compare
// depends on dcfr_pkg
module dcfr_slot_table #(
	parameter int SLOTS = dcfr_pkg::SLOTS_DEF,
	parameter int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [SW-1:0]      wr_idx,
	input  logic               wr_valid,
	input  dcfr_pkg::slot_cfg_t wr_cfg,
	input  logic               rd_en,
	input  logic [SW-1:0]      rd_idx,
	input  dcfr_pkg::probe_t   probe,
	output logic               match
);

	dcfr_pkg::slot_cfg_t cfg_q [SLOTS];
	logic [SLOTS-1:0]    valid_q;
	dcfr_pkg::slot_cfg_t ent_s1;
	logic                ent_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cfg_q[wr_idx] <= wr_cfg;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ent_s1 <= cfg_q[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			ent_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= wr_valid;
			end
			if (rd_en) begin
				ent_vld_s1 <= valid_q[rd_idx];
			end
		end
	end

	assign match = ent_vld_s1
		&& (ent_s1.dir == probe.dir)
		&& (probe.uni >= ent_s1.min_uni) && (probe.uni <= ent_s1.max_uni)
		&& (probe.ch >= ent_s1.min_ch) && (probe.ch <= ent_s1.max_ch);

endmodule

FILE: rtl/core/dcfr_frame_store.sv
// per-universe channel level memory and frame lengths with the change test
// depends on dcfr_pkg
module dcfr_frame_store #(
	parameter int UNIVERSES = dcfr_pkg::UNIVERSES_DEF,
	parameter int CHANNELS  = dcfr_pkg::CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_en,
	input  dcfr_pkg::frame_req_t req,
	input  logic                 commit,
	output logic                 fresh
);

	localparam int UW = (UNIVERSES > 1) ? $clog2(UNIVERSES) : 1;
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [dcfr_pkg::VAL_W-1:0] store_q [UNIVERSES][CHANNELS];
	logic [dcfr_pkg::CH_W-1:0]  len_q [UNIVERSES];
	dcfr_pkg::frame_req_t       req_q;
	logic [dcfr_pkg::VAL_W-1:0] rd_data_q;

	logic [dcfr_pkg::CH_W-1:0] ch_in_m1;
	logic [dcfr_pkg::CH_W-1:0] ch_q_m1;
	logic [UW-1:0]             uidx_in;
	logic [CW-1:0]             cidx_in;
	logic [UW-1:0]             uidx_q;
	logic [CW-1:0]             cidx_q;
	logic [dcfr_pkg::CH_W-1:0] cur_len;
	logic                      beyond;

	assign ch_in_m1 = req.ch - 10'd1;
	assign ch_q_m1  = req_q.ch - 10'd1;
	assign uidx_in  = UW'(req.uni);
	assign cidx_in  = CW'(ch_in_m1);
	assign uidx_q   = UW'(req_q.uni);
	assign cidx_q   = CW'(ch_q_m1);

	assign cur_len = len_q[uidx_q];
	assign beyond  = req_q.ch > cur_len;
	assign fresh   = beyond || (rd_data_q != req_q.val);

	always_ff @(posedge clk) begin
		if (req_en) begin
			req_q     <= req;
			rd_data_q <= store_q[uidx_in][cidx_in];
		end
	end

	always_ff @(posedge clk) begin
		if (commit && fresh) begin
			store_q[uidx_q][cidx_q] <= req_q.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int u = 0; u < UNIVERSES; u++) begin
				len_q[u] <= '0;
			end
		end else if (commit && beyond) begin
			len_q[uidx_q] <= req_q.ch;
		end
	end

endmodule

FILE: rtl/core/dmx_change_filter_router.sv
// top level of the dmx change filter router: beat decode, slot scan sequencer, output register
// depends on dcfr_pkg, dcfr_slot_table, dcfr_frame_store
//
// Slot writes and ignored beats are taken and the block stays ready. An incoming frame
// element first goes through a level lookup, and one whose level did not change ends after
// that lookup. A single event, an outgoing frame element or a changed incoming element then
// runs the slot scan: one slot a cycle while the output does not stall, through the table's
// single registered read port and the one shared match compare. Each delivery waits in the
// output register; a stalled output stalls the scan. While an item is at work s_axis_tready
// is low. At most 16 deliveries leave per item, in slot order, the final one with tlast high.
module dmx_change_filter_router #(
	parameter int SLOTS     = dcfr_pkg::SLOTS_DEF,
	parameter int UNIVERSES = dcfr_pkg::UNIVERSES_DEF,
	parameter int CHANNELS  = dcfr_pkg::CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// universe, channel, value, slot, enable, min_uni, max_uni,
	// min_ch, max_ch
	input  logic [55:0] s_axis_tdata,
	// kind, direction
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// subscriber, out_universe, out_channel, out_value
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t state_q;

	logic [dcfr_pkg::KIND_W-1:0] in_kind;
	logic                        in_dir;
	logic [dcfr_pkg::UNI_W-1:0]  in_uni;
	logic [dcfr_pkg::CH_W-1:0]   in_ch;
	logic [dcfr_pkg::VAL_W-1:0]  in_val;
	logic [dcfr_pkg::SUB_W-1:0]  in_slot;
	logic                        in_en;
	dcfr_pkg::slot_cfg_t         in_cfg;
	logic                        accept;
	logic                        frame_ok;
	logic                        slot_ok;

	dcfr_pkg::probe_t            item_q;
	logic [dcfr_pkg::VAL_W-1:0]  item_val_q;

	logic [SW:0]                 scan_q;
	logic [SW-1:0]               s1_idx_q;
	logic                        s1_live_q;
	logic                        pend_q;
	logic [SW-1:0]               pend_idx_q;
	logic [dcfr_pkg::CNT_W-1:0]  cnt_q;

	logic                        m_vld_q;
	logic [31:0]                 m_data_q;
	logic                        m_last_q;

	logic                        match;
	logic                        fresh;
	logic                        hit;
	logic                        can_out;
	logic                        done_scan;
	logic                        stall;
	logic                        rd_en;
	logic                        push;
	logic                        push_last;
	logic                        req_en;
	dcfr_pkg::frame_req_t        req;

	assign in_kind = s_axis_tuser[1:0];
	assign in_dir  = s_axis_tuser[2];
	assign in_uni  = s_axis_tdata[3:0];
	assign in_ch   = s_axis_tdata[13:4];
	assign in_val  = s_axis_tdata[21:14];
	assign in_slot = s_axis_tdata[25:22];
	assign in_en   = s_axis_tdata[26];
	assign in_cfg  = '{dir: in_dir, min_uni: s_axis_tdata[30:27], max_uni: s_axis_tdata[34:31],
		min_ch: s_axis_tdata[44:35], max_ch: s_axis_tdata[54:45]};

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign frame_ok = (in_ch != '0) && (32'(in_ch) <= 32'(CHANNELS))
		&& (32'(in_uni) < 32'(UNIVERSES));
	assign slot_ok  = 32'(in_slot) < 32'(SLOTS);

	assign req    = '{uni: in_uni, ch: in_ch, val: in_val};
	assign req_en = accept && (in_kind == dcfr_pkg::KIND_FRAME) && frame_ok
		&& (in_dir == dcfr_pkg::DIR_IN);

	assign hit       = s1_live_q && match;
	assign can_out   = !m_vld_q || m_axis_tready;
	assign done_scan = ((scan_q == (SW+1)'(SLOTS)) && !s1_live_q)
		|| (cnt_q == dcfr_pkg::CNT_W'(dcfr_pkg::MAX_RESULTS));
	assign stall     = hit && pend_q && !can_out;
	assign rd_en     = (state_q == ST_SCAN) && !done_scan && !stall
		&& (scan_q < (SW+1)'(SLOTS));

	always_comb begin
		push      = 1'b0;
		push_last = 1'b0;
		unique case (state_q)
			ST_SCAN: begin
				push = !done_scan && !stall && hit && pend_q;
			end
			ST_FLUSH: begin
				push      = can_out;
				push_last = 1'b1;
			end
			ST_IDLE, ST_CHECK: begin
				push = 1'b0;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	dcfr_slot_table #(
		.SLOTS (SLOTS),
		.SW    (SW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept && (in_kind == dcfr_pkg::KIND_SLOTWR) && slot_ok),
		.wr_idx   (SW'(in_slot)),
		.wr_valid (in_en),
		.wr_cfg   (in_cfg),
		.rd_en    (rd_en),
		.rd_idx   (scan_q[SW-1:0]),
		.probe    (item_q),
		.match    (match)
	);

	dcfr_frame_store #(
		.UNIVERSES (UNIVERSES),
		.CHANNELS  (CHANNELS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req_en (req_en),
		.req    (req),
		.commit (state_q == ST_CHECK),
		.fresh  (fresh)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q     <= '{dir: in_dir, uni: in_uni, ch: in_ch};
			item_val_q <= in_val;
		end
		if (rd_en) begin
			s1_idx_q <= scan_q[SW-1:0];
		end
		if (push) begin
			m_data_q <= {6'b0, item_val_q, item_q.ch, item_q.uni,
				dcfr_pkg::SUB_W'(pend_idx_q)};
			m_last_q <= push_last;
		end
		if ((state_q == ST_SCAN) && !done_scan && !stall && hit) begin
			pend_idx_q <= s1_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			scan_q    <= '0;
			s1_live_q <= 1'b0;
			pend_q    <= 1'b0;
			cnt_q     <= '0;
			m_vld_q   <= 1'b0;
		end else begin
			if (push) begin
				m_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					scan_q    <= '0;
					s1_live_q <= 1'b0;
					pend_q    <= 1'b0;
					cnt_q     <= '0;
					if (accept) begin
						if (in_kind == dcfr_pkg::KIND_EVENT) begin
							state_q <= ST_SCAN;
						end else if ((in_kind == dcfr_pkg::KIND_FRAME) && frame_ok) begin
							state_q <= (in_dir == dcfr_pkg::DIR_IN) ? ST_CHECK : ST_SCAN;
						end
					end
				end
				ST_CHECK: begin
					state_q <= fresh ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (done_scan) begin
						state_q <= pend_q ? ST_FLUSH : ST_IDLE;
					end else if (!stall) begin
						if (hit) begin
							pend_q <= 1'b1;
							cnt_q  <= cnt_q + 1'b1;
						end
						if (scan_q < (SW+1)'(SLOTS)) begin
							scan_q    <= scan_q + 1'b1;
							s1_live_q <= 1'b1;
						end else begin
							s1_live_q <= 1'b0;
						end
					end
				end
				ST_FLUSH: begin
					if (can_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

FILE: rtl/core/dcfr_checker.sv
// port-level checks for the dmx change filter router, bound to the top level
// depends on dcfr_pkg and dmx_change_filter_router
module dcfr_checker #(
	parameter int SLOTS = dcfr_pkg::SLOTS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [2:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	logic in_beat;

	assign in_beat = s_axis_tvalid && s_axis_tready;

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// an event occupies the block for its scan
	a_event_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && (s_axis_tuser[1:0] == dcfr_pkg::KIND_EVENT) |=> !s_axis_tready)
		else $error("ready after event beat");

	// slot writes finish in the beat cycle
	a_slotwr_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && (s_axis_tuser[1:0] == dcfr_pkg::KIND_SLOTWR) |=> s_axis_tready)
		else $error("slot write kept block busy");

	// subscriber number names an existing slot
	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(m_axis_tdata[3:0]) < 32'(SLOTS)) || (SLOTS > 16))
		else $error("subscriber out of range");

endmodule

bind dmx_change_filter_router dcfr_checker #(
	.SLOTS (SLOTS)
) u_dcfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

FILE: dv/tb_top.sv
// testbench for dmx_change_filter_router: directed and random beats through the stream ports
// a scoreboard class predicts slot fan-out and the incoming change filter; depends on dcfr_pkg
`timescale 1ns / 1ps

module tb_top;
	import dcfr_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 32;
	localparam int RANDOM_ITEMS = 230;

	typedef struct {
		bit [KIND_W-1:0] kind;
		bit              dir;
		bit [UNI_W-1:0]  uni;
		bit [CH_W-1:0]   ch;
		bit [VAL_W-1:0]  val;
		bit [SUB_W-1:0]  slot;
		bit              en;
		bit [UNI_W-1:0]  min_uni;
		bit [UNI_W-1:0]  max_uni;
		bit [CH_W-1:0]   min_ch;
		bit [CH_W-1:0]   max_ch;
	} route_item_t;

	typedef struct {
		bit [SUB_W-1:0] sub;
		bit [UNI_W-1:0] uni;
		bit [CH_W-1:0]  ch;
		bit [VAL_W-1:0] val;
		bit             last;
	} delivery_t;

	class delivery_board;
		slot_cfg_t      subs [SLOTS_DEF];
		bit             sub_on [SLOTS_DEF];
		bit [VAL_W-1:0] levels [UNIVERSES_DEF][CHANNELS_DEF];
		bit             written [UNIVERSES_DEF][CHANNELS_DEF];
		bit [CH_W-1:0]  frame_len [UNIVERSES_DEF];
		delivery_t      pending [$];
		int             errors;

		function new();
			foreach (sub_on[s]) begin
				sub_on[s] = 1'b0;
				subs[s] = '0;
			end
			foreach (frame_len[u]) frame_len[u] = '0;
			foreach (written[u, c]) begin
				written[u][c] = 1'b0;
				levels[u][c] = '0;
			end
			errors = 0;
		endfunction

		// an incoming element inside the stored length whose entry was never written
		function bit unsafe_read(route_item_t it);
			return it.kind == KIND_FRAME && it.dir == DIR_IN && it.ch != 0 &&
				it.ch <= CHANNELS_DEF && it.ch <= frame_len[it.uni] &&
				!written[it.uni][it.ch-1];
		endfunction

		function void fan_out(bit dir, bit [UNI_W-1:0] uni, bit [CH_W-1:0] ch,
				bit [VAL_W-1:0] val);
			delivery_t batch [$];
			delivery_t d;
			for (int s = 0; s < SLOTS_DEF; s++) begin
				if (!sub_on[s] || subs[s].dir != dir) continue;
				if (uni < subs[s].min_uni || uni > subs[s].max_uni) continue;
				if (ch < subs[s].min_ch || ch > subs[s].max_ch) continue;
				if (batch.size() >= MAX_RESULTS) break;
				d.sub = SUB_W'(s);
				d.uni = uni;
				d.ch = ch;
				d.val = val;
				d.last = 1'b0;
				batch.push_back(d);
			end
			if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
			foreach (batch[i]) pending.push_back(batch[i]);
		endfunction

		// returns 1 when the beat is one the block acts on
		function bit note_item(route_item_t it);
			bit fresh;
			case (it.kind)
				KIND_SLOTWR: begin
					sub_on[it.slot] = it.en;
					subs[it.slot] = '{dir: it.dir, min_uni: it.min_uni, max_uni: it.max_uni,
						min_ch: it.min_ch, max_ch: it.max_ch};
					return 1'b1;
				end
				KIND_EVENT: begin
					fan_out(it.dir, it.uni, it.ch, it.val);
					return 1'b1;
				end
				KIND_FRAME: begin
					if (it.ch == 0 || it.ch > CHANNELS_DEF) return 1'b0;
					if (it.dir == DIR_IN) begin
						if (it.ch > frame_len[it.uni]) begin
							fresh = 1'b1;
							frame_len[it.uni] = it.ch;
						end else begin
							fresh = levels[it.uni][it.ch-1] != it.val;
						end
						if (!fresh) return 1'b1;
						levels[it.uni][it.ch-1] = it.val;
						written[it.uni][it.ch-1] = 1'b1;
					end
					fan_out(it.dir, it.uni, it.ch, it.val);
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		endfunction

		function void check_delivery(delivery_t got);
			delivery_t want;
			if (pending.size() == 0) begin
				$error("unexpected delivery subscriber %0d channel %0d", got.sub, got.ch);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.sub != want.sub) begin
				$error("subscriber expected %0d actual %0d", want.sub, got.sub);
				errors++;
			end
			if (got.uni != want.uni) begin
				$error("out_universe expected %0d actual %0d", want.uni, got.uni);
				errors++;
			end
			if (got.ch != want.ch) begin
				$error("out_channel expected %0d actual %0d", want.ch, got.ch);
				errors++;
			end
			if (got.val != want.val) begin
				$error("out_value expected %0d actual %0d", want.val, got.val);
				errors++;
			end
			if (got.last != want.last) begin
				$error("last expected %0d actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_valid = 1'b0;
	logic [55:0] s_data = '0;
	logic [2:0]  s_user = '0;
	logic        m_ready = 1'b0;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;

	delivery_board board = new();
	bit calm = 1'b0;
	int items_used = 0;
	int cycles = 0;

	always #1 clk = ~clk;

	dmx_change_filter_router DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_data),
		.s_axis_tuser(s_user),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_ready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("dmx_change_filter_router verification failed");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		delivery_t got;
		if (!arst_n) begin
			m_ready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_ready) begin
				got.sub = m_axis_tdata[3:0];
				got.uni = m_axis_tdata[7:4];
				got.ch = m_axis_tdata[17:8];
				got.val = m_axis_tdata[25:18];
				got.last = m_axis_tlast;
				board.check_delivery(got);
			end
			m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic route_item_t mk_beat(bit [KIND_W-1:0] kind, bit dir,
			bit [UNI_W-1:0] uni, bit [CH_W-1:0] ch, bit [VAL_W-1:0] val);
		route_item_t it;
		it.kind = kind;
		it.dir = dir;
		it.uni = uni;
		it.ch = ch;
		it.val = val;
		it.slot = SUB_W'($urandom);
		it.en = 1'($urandom);
		it.min_uni = UNI_W'($urandom);
		it.max_uni = UNI_W'($urandom);
		it.min_ch = CH_W'($urandom);
		it.max_ch = CH_W'($urandom);
		return it;
	endfunction

	function automatic route_item_t mk_slot(bit [SUB_W-1:0] slot, bit en, bit dir,
			bit [UNI_W-1:0] min_uni, bit [UNI_W-1:0] max_uni,
			bit [CH_W-1:0] min_ch, bit [CH_W-1:0] max_ch);
		route_item_t it;
		it = mk_beat(KIND_SLOTWR, dir, UNI_W'($urandom), CH_W'($urandom), VAL_W'($urandom));
		it.slot = slot;
		it.en = en;
		it.min_uni = min_uni;
		it.max_uni = max_uni;
		it.min_ch = min_ch;
		it.max_ch = max_ch;
		return it;
	endfunction

	task automatic send_item(input route_item_t it);
		if (board.unsafe_read(it)) it.ch = '0;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_valid <= 1'b0;
			@(posedge clk);
		end
		s_valid <= 1'b1;
		s_data <= {1'b0, it.max_ch, it.min_ch, it.max_uni, it.min_uni, it.en, it.slot,
			it.val, it.ch, it.uni};
		s_user <= {it.dir, it.kind};
		do @(posedge clk); while (!s_axis_tready);
		if (board.note_item(it)) items_used++;
	endtask

	task automatic send_frame_run(input bit dir);
		bit [UNI_W-1:0] u;
		int n;
		bit [VAL_W-1:0] v;
		u = UNI_W'($urandom);
		n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
		for (int c = 1; c <= n; c++) begin
			v = VAL_W'($urandom);
			if (dir == DIR_IN && board.written[u][c-1] && $urandom_range(1))
				v = board.levels[u][c-1];
			send_item(mk_beat(KIND_FRAME, dir, u, CH_W'(c), v));
		end
	endtask

	task automatic send_random_slot();
		if ($urandom_range(9) < 6)
			send_item(mk_slot(SUB_W'($urandom), $urandom_range(99) < 85, 1'($urandom),
				UNI_W'($urandom_range(3)), UNI_W'($urandom_range(15, 12)),
				CH_W'($urandom_range(8)), CH_W'($urandom_range(512, 6))));
		else
			send_item(mk_slot(SUB_W'($urandom), 1'($urandom), 1'($urandom),
				UNI_W'($urandom), UNI_W'($urandom), CH_W'($urandom), CH_W'($urandom)));
	endtask

	initial begin
		int pick;
		bit paused;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: table extremes, filter cases, ignored beats
		send_item(mk_slot(0, 1'b1, DIR_IN, 0, 15, 0, 512));
		send_item(mk_slot(15, 1'b1, DIR_OUT, 0, 15, 0, 512));
		send_item(mk_slot(5, 1'b1, DIR_IN, 3, 3, 10, 20));
		send_item(mk_slot(7, 1'b1, DIR_IN, 9, 2, 0, 512));
		send_item(mk_slot(8, 1'b1, DIR_IN, 0, 15, 300, 100));
		send_item(mk_beat(KIND_EVENT, DIR_IN, 3, 15, 8'hff));
		send_item(mk_beat(KIND_EVENT, DIR_OUT, 15, 512, 8'h00));
		send_item(mk_beat(KIND_EVENT, DIR_IN, 0, 0, 8'h5a));
		send_item(mk_beat(KIND_EVENT, DIR_IN, 15, 1023, 8'h01));
		send_item(mk_beat(KIND_FRAME, DIR_IN, 3, 1, 8'haa));
		send_item(mk_beat(KIND_FRAME, DIR_IN, 3, 1, 8'haa));
		send_item(mk_beat(KIND_FRAME, DIR_IN, 3, 1, 8'h55));
		send_item(mk_beat(KIND_FRAME, DIR_IN, 3, 2, 8'h00));
		send_item(mk_beat(KIND_FRAME, DIR_OUT, 3, 1, 8'haa));
		send_item(mk_beat(KIND_FRAME, DIR_IN, 3, 0, 8'h11));
		send_item(mk_beat(KIND_FRAME, DIR_IN, 3, 513, 8'h22));
		send_item(mk_beat(KIND_FRAME, DIR_OUT, 0, 1023, 8'h33));
		send_item(mk_beat(KIND_SPARE, DIR_IN, 3, 15, 8'h44));
		send_item(mk_beat(KIND_FRAME, DIR_IN, 15, 1, 8'h07));
		send_item(mk_beat(KIND_FRAME, DIR_IN, 15, 512, 8'hfe));
		send_item(mk_slot(5, 1'b0, DIR_IN, 3, 3, 10, 20));
		send_item(mk_beat(KIND_EVENT, DIR_IN, 3, 15, 8'h80));

		// fill every slot so one beat fans out to all of them
		for (int s = 0; s < SLOTS_DEF; s++)
			send_item(mk_slot(SUB_W'(s), 1'b1, DIR_IN, 0, 15, 0, 512));
		send_item(mk_beat(KIND_EVENT, DIR_IN, 9, 300, 8'hc3));

		items_used = 0;
		paused = 1'b0;
		while (items_used < RANDOM_ITEMS) begin
			calm = items_used >= 100 && items_used < 160;
			if (!paused && items_used >= 200) begin
				paused = 1'b1;
				s_valid <= 1'b0;
				while (board.pending.size() != 0) @(posedge clk);
				repeat (5) @(posedge clk);
			end
			pick = $urandom_range(99);
			if (pick < 15) send_random_slot();
			else if (pick < 55) send_frame_run(DIR_IN);
			else if (pick < 65) send_frame_run(DIR_OUT);
			else if (pick < 85)
				send_item(mk_beat(KIND_EVENT, 1'($urandom), UNI_W'($urandom),
					($urandom_range(9) < 7) ? CH_W'($urandom_range(40, 1)) : CH_W'($urandom),
					VAL_W'($urandom)));
			else
				send_item(mk_beat(KIND_W'($urandom), 1'($urandom), UNI_W'($urandom),
					CH_W'($urandom), VAL_W'($urandom)));
		end
		calm = 1'b0;
		s_valid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (SLOTS_DEF * 4) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("dmx_change_filter_router verification clean");
		end else begin
			$display("dmx_change_filter_router verification failed");
		end
		$finish;
	end

endmodule

FILE: dmx_change_filter_router.f
rtl/core/dcfr_pkg.sv
rtl/core/dcfr_slot_table.sv
rtl/core/dcfr_frame_store.sv
rtl/core/dmx_change_filter_router.sv
rtl/core/dcfr_checker.sv
dv/tb_top.sv
